[rtl/core/kli_pkg.sv]
// Package for the keyframe linear interpolator: widths, status codes, defaults.
// No dependencies.
package kli_pkg;
  localparam int MaxKeysDefault = 16;
  localparam int FracBits = 24;
  typedef enum logic [1:0] {
    ST_SAMPLE_OK = 2'd0,
    ST_NO_SAMPLE = 2'd1,
    ST_STORED    = 2'd2,
    ST_DROPPED   = 2'd3
  } status_t;
endpackage

[rtl/core/keyframe_linear_interpolator_unit.sv]
// Keyframe linear interpolator: key table, serial modulo, search, divide, multiply.
// Depends on kli_pkg.
// An append has its result in the cycle after it is accepted. A sample fetches the
// first and last key times, reduces the time modulo the last key time (loop mode only),
// clamps it, searches the keys, fetches the earlier key of the pair, divides and
// multiplies. One request at a time; in_ready returns the cycle after the result
// is taken. Reset (rst, synchronous) empties the table and clears loop mode; key
// storage itself is not cleared.
module keyframe_linear_interpolator_unit #(
  parameter int MAX_KEYS = kli_pkg::MaxKeysDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [30:0]        key_time,
  input  logic signed [31:0] key_value,
  input  logic signed [31:0] sample_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] value
);
  localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHK   = 9'b000000010,
    S_MOD   = 9'b000000100,
    S_CLAMP = 9'b000001000,
    S_SRCH  = 9'b000010000,
    S_RD    = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_MUL   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic loop_mode;
  logic [CW-1:0] key_count;
  logic [31:0] times_mem [MAX_KEYS];
  logic signed [31:0] values_mem [MAX_KEYS];

  // Read port registered; address chosen by the sequencer.
  logic [IW-1:0] rd_addr;
  logic [31:0] rd_time;
  logic signed [31:0] rd_val;

  logic signed [33:0] t;      // working sample time
  logic [31:0] tmin, tmax, t1;
  logic signed [31:0] v0, v1;
  logic signed [32:0] dv;     // value step between the two keys
  logic [IW-1:0] idx;
  logic [5:0] cnt;
  logic [2:0] phase;
  // Shared shift-subtract unit: remainder and quotient registers.
  logic [63:0] rem;
  logic [23:0] quo;
  logic [63:0] dvs;
  logic signed [58:0] prod;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    rd_time <= times_mem[rd_addr];
    rd_val  <= values_mem[rd_addr];
    if (in_valid && in_ready && !operation && (key_count < CW'(MAX_KEYS))) begin
      times_mem[key_count[IW-1:0]]  <= {1'b0, key_time};
      values_mem[key_count[IW-1:0]] <= key_value;
    end
  end

  logic [64:0] diff;
  assign diff = {1'b0, rem} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      loop_mode <= 1'b0;
      key_count <= '0;
      out_valid <= 1'b0;
      phase <= '0;
    end else begin
      if (cfg_we) loop_mode <= cfg_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (!operation) begin
              // Append: store unless the table is full.
              out_valid <= 1'b1;
              value <= '0;
              if (key_count < CW'(MAX_KEYS)) begin
                key_count <= key_count + 1'b1;
                status <= kli_pkg::ST_STORED;
              end else begin
                status <= kli_pkg::ST_DROPPED;
              end
            end else begin
              t <= 34'(sample_time);
              rd_addr <= '0;
              phase <= '0;
              state <= S_CHK;
            end
          end
        end
        S_CHK: begin
          // Fetch first and last key time through the read port.
          phase <= phase + 1'b1;
          if (phase == 3'd0) begin
            if (key_count < CW'(2)) begin
              status <= kli_pkg::ST_NO_SAMPLE;
              value <= '0;
              out_valid <= 1'b1;
              state <= S_IDLE;
            end
            rd_addr <= IW'(key_count - 1'b1);
          end else if (phase == 3'd1) begin
            tmin <= rd_time;
          end else begin
            tmax <= rd_time;
            if (rd_time == 32'd0) begin
              status <= kli_pkg::ST_NO_SAMPLE;
              value <= '0;
              out_valid <= 1'b1;
              state <= S_IDLE;
            end else if (loop_mode) begin
              // Floor modulo via magnitude remainder then sign fix.
              rem <= 64'(t[33] ? -t : t);
              dvs <= {1'b0, rd_time, 31'd0};
              cnt <= 6'd0;
              state <= S_MOD;
            end else begin
              state <= S_CLAMP;
            end
          end
        end
        S_MOD: begin
          // Restoring remainder: divisor starts shifted by 31, walks down.
          if (!diff[64]) rem <= diff[63:0];
          dvs <= dvs >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == 6'd31) begin
            state <= S_CLAMP;
            if (t[33] && (diff[64] ? rem : diff[63:0]) != 64'd0)
              t <= 34'(tmax) - 34'(diff[64] ? rem : diff[63:0]);
            else
              t <= 34'(diff[64] ? rem : diff[63:0]);
          end
        end
        S_CLAMP: begin
          if (t < $signed({2'b00, tmin})) t <= $signed({2'b00, tmin});
          else if (t >= $signed({2'b00, tmax})) t <= $signed({2'b00, tmax}) - 34'sd1;
          idx <= IW'(1);
          rd_addr <= IW'(1);
          phase <= '0;
          state <= S_SRCH;
        end
        S_SRCH: begin
          // Each key has a wait phase and a compare phase; the wait lets the registered read settle.
          if (phase == 3'd0) begin
            phase <= 3'd1;
          end else if ((CW'(idx) < key_count - 1'b1) &&
                       ($signed({2'b00, rd_time}) <= t)) begin
            idx <= idx + 1'b1;
            rd_addr <= idx + 1'b1;
            phase <= 3'd0;
          end else begin
            t1 <= rd_time;
            v1 <= rd_val;
            rd_addr <= idx - 1'b1;
            phase <= 3'd0;
            state <= S_RD;
          end
        end
        S_RD: begin
          phase <= phase + 1'b1;
          if (phase == 3'd1) begin
            v0 <= rd_val;
            dv <= 33'(v1) - 33'(rd_val);
            if (t1 <= rd_time) begin
              status <= kli_pkg::ST_SAMPLE_OK;
              value <= v1;
              out_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              // Numerator clamped to [0, span], shifted up by the fraction bits.
              rem <= (t < $signed({2'b00, rd_time})) ? 64'd0 :
                     ((t - $signed({2'b00, rd_time})) > $signed({2'b00, t1 - rd_time})) ?
                     {8'd0, t1 - rd_time, 24'd0} :
                     {8'd0, 32'(t - $signed({2'b00, rd_time})), 24'd0};
              dvs <= {8'd0, t1 - rd_time, 24'd0};
              quo <= '0;
              cnt <= '0;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (!diff[64]) rem <= diff[63:0];
          quo <= {quo[22:0], !diff[64]};
          dvs <= dvs >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == 6'd24) begin
            prod <= dv * $signed({1'b0, quo, !diff[64]});
            state <= S_MUL;
          end
        end
        S_MUL: begin
          value <= 32'(v0 + (prod >>> kli_pkg::FracBits));
          status <= kli_pkg::ST_SAMPLE_OK;
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
